// ===== design/ugat_pkg.sv =====
// Shared types and constants for the ultimate gain autotuner.
// Used by ugat_tracker, ugat_scaler and ultimate_gain_autotuner_core.
package ugat_pkg;

  localparam int TEMP_W   = 16;
  localparam int TICK_W   = 16;
  localparam int GAIN_W   = 24;
  localparam int TIME_W   = 32;
  localparam int POWER_W  = 10;
  localparam int COUNT_W  = 2;
  localparam int DIFF_W   = 16;
  localparam int PROD_W   = GAIN_W + DIFF_W;
  localparam int LOW_W    = 20;

  localparam logic [GAIN_W-1:0]  GAIN_MAX   = 24'hFF_FFFF;
  localparam logic [GAIN_W-1:0]  GAIN_RESET = 24'd100;
  localparam logic [POWER_W-1:0] POWER_MAX  = 10'd999;
  localparam logic [COUNT_W-1:0] CROSSINGS_NEEDED = 2'd2;

  // Any product at or above this value divides to more than the power limit.
  localparam logic [PROD_W-1:0] SAT_PRODUCT = 40'd1000000;

  // Reciprocal of 1000 scaled by 2**30, rounded up; exact for products below 2**20.
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_W     = 21;
  localparam logic [RECIP_W-1:0] RECIP_K = 21'd1073742;

  typedef struct packed {
    logic              done;
    logic [GAIN_W-1:0] ugain;
    logic [TIME_W-1:0] uperiod;
  } tune_res_t;

endpackage

// ===== design/ugat_tracker.sv =====
// Crossing detector, time stamps and gain ramp of the autotuner.
// Depends on ugat_pkg.
module ugat_tracker import ugat_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [GAIN_W-1:0]        cfg_wr_data,
  input  logic                     adv,
  input  logic signed [TEMP_W-1:0] temp_now,
  input  logic signed [TEMP_W-1:0] target_temp,
  input  logic [TICK_W-1:0]        tick_time,
  output logic [GAIN_W-1:0]        gain,
  output tune_res_t                res
);

  logic signed [TEMP_W-1:0] previous_temp;
  logic [TIME_W-1:0]        elapsed_time;
  logic [TIME_W-1:0]        crossing_time0;
  logic [TIME_W-1:0]        crossing_time1;
  logic [COUNT_W-1:0]       crossing_count;

  logic                     crossing;
  logic [COUNT_W-1:0]       count_inc;
  logic [TIME_W-1:0]        crossing_time0_next;
  logic [TIME_W-1:0]        crossing_time1_next;
  logic [GAIN_W-1:0]        gain_next;
  logic [COUNT_W-1:0]       crossing_count_next;

  always_comb begin
    crossing = (temp_now > target_temp) && (previous_temp < target_temp);
    count_inc = crossing ? crossing_count + 2'd1 : crossing_count;
    crossing_time0_next = crossing_time0;
    crossing_time1_next = crossing_time1;
    if (crossing && (crossing_count < CROSSINGS_NEEDED)) begin
      if (crossing_count[0]) begin
        crossing_time1_next = elapsed_time;
      end else begin
        crossing_time0_next = elapsed_time;
      end
    end
    res.done    = (count_inc >= CROSSINGS_NEEDED);
    res.ugain   = res.done ? gain : '0;
    res.uperiod = res.done ? (crossing_time1_next - crossing_time0_next) : '0;
    crossing_count_next = res.done ? '0 : count_inc;
    if (res.done || (gain == GAIN_MAX)) begin
      gain_next = gain;
    end else begin
      gain_next = gain + 24'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_temp  <= '0;
      elapsed_time   <= '0;
      crossing_time0 <= '0;
      crossing_time1 <= '0;
      crossing_count <= '0;
      gain           <= GAIN_RESET;
    end else if (cfg_wr_en) begin
      gain <= cfg_wr_data;
    end else if (adv) begin
      previous_temp  <= temp_now;
      elapsed_time   <= elapsed_time + {{(TIME_W-TICK_W){1'b0}}, tick_time};
      crossing_time0 <= crossing_time0_next;
      crossing_time1 <= crossing_time1_next;
      crossing_count <= crossing_count_next;
      gain           <= gain_next;
    end
  end

endmodule

// ===== design/ugat_scaler.sv =====
// Divides the registered drive product by 1000 and clamps it to the power limit.
// Depends on ugat_pkg.
module ugat_scaler import ugat_pkg::*; (
  input  logic               sat,
  input  logic [LOW_W-1:0]   prod_low,
  output logic [POWER_W-1:0] power
);

  localparam int WIDE_W = LOW_W + RECIP_W;

  logic [WIDE_W-1:0] wide;

  always_comb begin
    wide  = {{RECIP_W{1'b0}}, prod_low} * {{LOW_W{1'b0}}, RECIP_K};
    power = sat ? POWER_MAX : wide[RECIP_SHIFT +: POWER_W];
  end

endmodule

// ===== design/ultimate_gain_autotuner_core.sv =====
// Top level of the ultimate gain autotuner: three-stage stream pipeline.
// Depends on ugat_pkg, ugat_tracker and ugat_scaler.
//
//   channel  dir  fields (lowest bit first)
//   s_axis   in   tdata: temp_now[15:0], target_temp[31:16], tick_time[47:32]
//   m_axis   out  tdata: heater_power[9:0], ultimate_gain[33:10], ultimate_period[65:34]
//                 tuser: tuning_done
//   cfg_wr   in   initial_gain, also loads the running gain
//
// One word per cycle sustained while the output is ready; a taken word passes through
// one register each for the input, the gain multiply and the divide by 1000, in that
// order, before it is presented on the output.
// Synchronous reset empties all stages and restores the tracker state.
// A stalled output holds its word while earlier stages keep filling behind it.
module ultimate_gain_autotuner_core import ugat_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [GAIN_W-1:0] cfg_wr_data,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [47:0]       s_axis_tdata,   // temp_now, target_temp, tick_time
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [71:0]       m_axis_tdata,   // heater_power, ultimate_gain, ultimate_period
  output logic [0:0]        m_axis_tuser    // tuning_done
);

  // Stage 1: input register.
  logic                     v1;
  logic signed [TEMP_W-1:0] temp1;
  logic signed [TEMP_W-1:0] target1;
  logic [TICK_W-1:0]        tick1;
  // Stage 2: product register.
  logic                     v2;
  logic                     sat2;
  logic [LOW_W-1:0]         low2;
  tune_res_t                res2;
  // Stage 3: output register.
  logic                     v3;
  logic [POWER_W-1:0]       power3;
  tune_res_t                res3;

  logic                     adv1;
  logic                     adv2;
  logic                     take;
  logic [GAIN_W-1:0]        gain;
  tune_res_t                res1;
  logic [DIFF_W-1:0]        diff;
  logic [PROD_W-1:0]        prod;
  logic [POWER_W-1:0]       power2;

  assign adv2 = v2 && (!v3 || m_axis_tready);
  assign adv1 = v1 && (!v2 || adv2);
  assign s_axis_tready = !v1 || adv1;
  assign take = s_axis_tvalid && s_axis_tready;

  ugat_tracker u_tracker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .adv         (adv1),
    .temp_now    (temp1),
    .target_temp (target1),
    .tick_time   (tick1),
    .gain        (gain),
    .res         (res1)
  );

  // The difference only matters when positive, where it fits in 16 unsigned bits.
  always_comb begin
    diff = (temp1 < target1) ? DIFF_W'(target1 - temp1) : '0;
    prod = {{DIFF_W{1'b0}}, gain} * {{GAIN_W{1'b0}}, diff};
  end

  ugat_scaler u_scaler (
    .sat      (sat2),
    .prod_low (low2),
    .power    (power2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (take) begin
        v1 <= 1'b1;
      end else if (adv1) begin
        v1 <= 1'b0;
      end
      if (adv1) begin
        v2 <= 1'b1;
      end else if (adv2) begin
        v2 <= 1'b0;
      end
      if (adv2) begin
        v3 <= 1'b1;
      end else if (m_axis_tready) begin
        v3 <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      temp1   <= s_axis_tdata[15:0];
      target1 <= s_axis_tdata[31:16];
      tick1   <= s_axis_tdata[47:32];
    end
    if (adv1) begin
      sat2 <= (prod >= SAT_PRODUCT);
      low2 <= prod[LOW_W-1:0];
      res2 <= res1;
    end
    if (adv2) begin
      power3 <= power2;
      res3   <= res2;
    end
  end

  assign m_axis_tvalid = v3;
  assign m_axis_tdata  = {6'd0, res3.uperiod, res3.ugain, power3};
  assign m_axis_tuser  = res3.done;

`ifndef SYNTHESIS
  a_power_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[9:0] <= POWER_MAX))
    else $error("heater power above limit");

  a_idle_results_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[71:10] == '0))
    else $error("tuning results nonzero on a word without completion");

  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  a_pipe_advance: assert property (@(posedge clk) disable iff (rst)
    (v2 && !v3) |=> v3)
    else $error("product stage failed to move into empty output stage");
`endif

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for ultimate_gain_autotuner_core: a directed table, then random swings.
// Expected words come from a predictor kept inside the bench, or from typed table rows.
// Depends on ugat_pkg and on the design files.
`timescale 1ns / 100ps

module testbench import ugat_pkg::*; ();

  localparam int GAIN_SCALE = 1000;
  localparam int PLAN_LEN = 22;

  typedef struct packed {
    logic [POWER_W-1:0] power;
    logic               done;
    logic [GAIN_W-1:0]  ugain;
    logic [TIME_W-1:0]  uperiod;
  } heater_word_t;

  typedef enum logic {ROW_TICK, ROW_GAIN} row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic signed [TEMP_W-1:0] temp;
    logic signed [TEMP_W-1:0] target;
    logic [TICK_W-1:0]        tick;
    logic [GAIN_W-1:0]        gain;
    logic                     typed;
    heater_word_t             want;
  } plan_row_t;

  localparam heater_word_t COLD_WORD = '0;
  localparam heater_word_t FULL_WORD = {POWER_MAX, 1'b0, 24'd0, 32'd0};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [GAIN_W-1:0]  cfg_wr_data = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [47:0]        s_axis_tdata = '0;   // temp_now, target_temp, tick_time
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b1;
  logic [71:0]        m_axis_tdata;        // heater_power, ultimate_gain, ultimate_period
  logic [0:0]         m_axis_tuser;        // tuning_done

  // Predictor state, mirroring the tracker after reset.
  logic signed [TEMP_W-1:0] held_temp = '0;
  logic [TIME_W-1:0]        clock_ms = '0;
  logic [TIME_W-1:0]        cross_stamp [2] = '{32'd0, 32'd0};
  logic [COUNT_W-1:0]       cross_seen = '0;
  logic [GAIN_W-1:0]        run_gain = GAIN_RESET;

  heater_word_t             due_words [$];
  int                       mismatch_count = 0;
  int                       word_count = 0;
  int                       idle_odds = 0;
  int unsigned              sink_hold = 0;
  logic signed [TEMP_W-1:0] swing_aim = '0;
  logic                     swing_up = 1'b0;

  // Directed rows: extremes, exact equality, a full tuning cycle, gain saturation and zero gain.
  plan_row_t plan [PLAN_LEN] = '{
    '{ROW_TICK, 16'sd0,     16'sd0,     16'd0,     24'd0,        1'b1, COLD_WORD},
    '{ROW_TICK, 16'sh8000,  16'sh7FFF,  16'hFFFF,  24'd0,        1'b1, FULL_WORD},
    '{ROW_TICK, 16'sh7FFF,  16'sh8000,  16'd0,     24'd0,        1'b1, COLD_WORD},
    '{ROW_TICK, -16'sd10,   16'sd0,     16'd100,   24'd0,        1'b0, COLD_WORD},
    '{ROW_TICK, 16'sd10,    16'sd0,     16'd200,   24'd0,        1'b0, COLD_WORD},
    '{ROW_TICK, 16'sd0,     16'sd0,     16'd50,    24'd0,        1'b0, COLD_WORD},
    '{ROW_TICK, 16'sd5,     16'sd0,     16'd50,    24'd0,        1'b0, COLD_WORD},
    '{ROW_TICK, -16'sd5,    16'sd0,     16'd300,   24'd0,        1'b0, COLD_WORD},
    '{ROW_TICK, 16'sd1,     16'sd0,     16'd0,     24'd0,        1'b0, COLD_WORD},
    '{ROW_GAIN, 16'sd0,     16'sd0,     16'd0,     24'hFF_FFFF,  1'b0, COLD_WORD},
    '{ROW_TICK, 16'sh8000,  16'sh7FFF,  16'd1234,  24'd0,        1'b1, FULL_WORD},
    '{ROW_TICK, 16'sd100,   16'sd101,   16'd7,     24'd0,        1'b1, FULL_WORD},
    '{ROW_TICK, 16'sd200,   16'sd101,   16'd5000,  24'd0,        1'b0, COLD_WORD},
    '{ROW_TICK, 16'sd0,     16'sd101,   16'hFFFF,  24'd0,        1'b0, COLD_WORD},
    '{ROW_TICK, 16'sd500,   16'sd101,   16'd1,     24'd0,        1'b0, COLD_WORD},
    '{ROW_GAIN, 16'sd0,     16'sd0,     16'd0,     24'd0,        1'b0, COLD_WORD},
    '{ROW_TICK, 16'sh8000,  16'sh7FFF,  16'd0,     24'd0,        1'b1, COLD_WORD},
    '{ROW_TICK, 16'sh8000,  16'sh7FFF,  16'd0,     24'd0,        1'b0, COLD_WORD},
    '{ROW_GAIN, 16'sd0,     16'sd0,     16'd0,     24'd1000,     1'b0, COLD_WORD},
    '{ROW_TICK, 16'sd0,     16'sd999,   16'd10,    24'd0,        1'b0, COLD_WORD},
    '{ROW_TICK, 16'sd0,     16'sd1000,  16'd10,    24'd0,        1'b0, COLD_WORD},
    '{ROW_TICK, 16'sd20000, -16'sd20000, 16'd3,    24'd0,        1'b0, COLD_WORD}
  };

  ultimate_gain_autotuner_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk = ~clk;

  // One control tick: proportional drive, crossing bookkeeping and gain ramp.
  function automatic heater_word_t autotune_tick(input logic signed [TEMP_W-1:0] temp,
                                                 input logic signed [TEMP_W-1:0] target,
                                                 input logic [TICK_W-1:0] tick);
    heater_word_t w;
    longint       drive;
    w = '0;
    if (temp < target) begin
      drive = longint'(run_gain) * longint'(int'(target) - int'(temp)) / GAIN_SCALE;
      w.power = (drive > longint'(POWER_MAX)) ? POWER_MAX : drive[POWER_W-1:0];
    end
    if (temp > target && held_temp < target) begin
      if (cross_seen < CROSSINGS_NEEDED)
        cross_stamp[cross_seen[0]] = clock_ms;
      cross_seen = cross_seen + 1'b1;
    end
    held_temp = temp;
    clock_ms = clock_ms + TIME_W'(tick);
    if (cross_seen >= CROSSINGS_NEEDED) begin
      w.done = 1'b1;
      w.ugain = run_gain;
      w.uperiod = cross_stamp[1] - cross_stamp[0];
      cross_seen = '0;
    end else if (run_gain < GAIN_MAX) begin
      run_gain = run_gain + 1'b1;
    end
    return w;
  endfunction

  // Called right after a rising edge; returns at the edge that takes the word.
  task automatic send_tick(input logic signed [TEMP_W-1:0] temp,
                           input logic signed [TEMP_W-1:0] target,
                           input logic [TICK_W-1:0] tick,
                           input logic typed, input heater_word_t want);
    heater_word_t predicted;
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {tick, target, temp};
    do @(posedge clk); while (!s_axis_tready);
    predicted = autotune_tick(temp, target, tick);
    due_words.push_back(typed ? want : predicted);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The gain register also reloads the running gain.
  task automatic load_gain(input logic [GAIN_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    run_gain = value;
  endtask

  // Temperature swinging around a slowly moving target, with some pure noise mixed in.
  task automatic swing_run(input int count, input logic wrap_mode);
    int                       offset;
    int                       level;
    logic signed [TEMP_W-1:0] temp;
    logic signed [TEMP_W-1:0] target;
    logic [TICK_W-1:0]        tick;
    for (int n = 0; n < count; n++) begin
      if (wrap_mode)
        idle_odds = 0;
      else if (n % 50 == 0)
        case ($urandom_range(0, 2))
          0: idle_odds = 0;
          1: idle_odds = 8;
          default: idle_odds = 2;
        endcase
      if ($urandom_range(0, 99) < 12) begin
        temp = TEMP_W'($urandom);
        target = TEMP_W'($urandom);
      end else begin
        if ($urandom_range(0, 29) == 0)
          swing_aim = TEMP_W'($urandom);
        if ($urandom_range(0, 9) == 0)
          offset = $urandom_range(0, 40000);
        else
          offset = $urandom_range(0, 300);
        if ($urandom_range(0, 15) == 0)
          offset = 0;
        if ($urandom_range(0, 1) == 1)
          swing_up = ~swing_up;
        level = swing_up ? int'(swing_aim) + offset : int'(swing_aim) - offset;
        if (level > 32767)
          level = 32767;
        if (level < -32768)
          level = -32768;
        temp = level[TEMP_W-1:0];
        target = swing_aim;
      end
      if (wrap_mode)
        tick = 16'hFFFF;
      else
        case ($urandom_range(0, 9))
          0: tick = '0;
          1: tick = 16'hFFFF;
          default: tick = TICK_W'($urandom_range(0, 65535));
        endcase
      send_tick(temp, target, tick, 1'b0, COLD_WORD);
    end
    drain();
  endtask

  task automatic report_word(input string what, input heater_word_t want,
                             input heater_word_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("word %0d %s: expected power %0d done %0d gain %0d period %0d,",
               word_count, what, want.power, want.done, want.ugain, want.uperiod,
               " got power %0d done %0d gain %0d period %0d",
               got.power, got.done, got.ugain, got.uperiod);
  endtask

  // Output stall bursts follow the same idle setting as the sender.
  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
      m_axis_tready <= (sink_hold == 1);
    end else if (idle_odds != 0 && $urandom_range(1, idle_odds + 2) == 1) begin
      sink_hold <= $urandom_range(1, 8);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_words
    heater_word_t got;
    heater_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.power = m_axis_tdata[9:0];
      got.ugain = m_axis_tdata[33:10];
      got.uperiod = m_axis_tdata[65:34];
      got.done = m_axis_tuser[0];
      if (due_words.size() == 0) begin
        report_word("unexpected", COLD_WORD, got);
      end else begin
        want = due_words.pop_front();
        if (got.power !== want.power || got.done !== want.done ||
            got.ugain !== want.ugain || got.uperiod !== want.uperiod)
          report_word("differs", want, got);
      end
      word_count++;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_odds = 3;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_GAIN) begin
        drain();
        load_gain(plan[i].gain);
      end else begin
        send_tick(plan[i].temp, plan[i].target, plan[i].tick, plan[i].typed, plan[i].want);
      end
    end
    drain();

    load_gain(GAIN_W'($urandom_range(0, 2000)));
    swing_run(250, 1'b0);
    load_gain(GAIN_W'(GAIN_MAX - $urandom_range(0, 300)));
    swing_run(200, 1'b0);
    load_gain(GAIN_W'($urandom));
    swing_run(150, 1'b0);

    // Closing run at the largest tick with no idling on either side.
    load_gain(GAIN_W'($urandom_range(50, 5000)));
    swing_run(200, 1'b1);

    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("ultimate_gain_autotuner_core: match");
    else
      $display("ultimate_gain_autotuner_core: mismatch");
    $finish;
  end

  initial begin
    #(64'd60_000_000);
    $display("ultimate_gain_autotuner_core: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/ugat_pkg.sv
design/ugat_tracker.sv
design/ugat_scaler.sv
design/ultimate_gain_autotuner_core.sv
bench/testbench.sv
